// ===== hw/rtl/evmc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the elastic velocity / moduli converter.
// Used by the top level of the converter and its bench; depends on nothing else.
package evmc_pkg;

    localparam int VAL_W         = 64;
    localparam int DENS_W        = 32;
    localparam int PROD_W        = 2 * VAL_W + DENS_W;
    localparam int DIFF_W        = PROD_W + 2;
    localparam int MOD_W         = 66;
    localparam int DIV_W         = DENS_W + 2;
    localparam int IN_W          = DENS_W + 2 * VAL_W;
    localparam int OUT_W         = 136;
    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SAT     = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // Smallest magnitudes whose third no longer fits the positive or negative bound.
    localparam logic [MOD_W-1:0] LIM_POS   = 66'h1_8000_0000_0000_0000;
    localparam logic [MOD_W-1:0] LIM_NEG   = 66'h1_8000_0000_0000_0003;
    localparam logic [DIV_W-1:0] DIV_THREE = 34'd3;
    localparam logic [VAL_W-1:0] S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] S64_MIN   = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic              dir;
        logic [DENS_W-1:0] dens;
        logic [VAL_W-1:0]  a;
        logic [VAL_W-1:0]  b;
    } t_raw;

    typedef struct packed {
        logic       dir;
        logic       sat_x;
        logic [62:0] x_lo;
        logic       neg;
        logic       sat_b;
        logic       bad;
    } t_tag;

    function automatic logic [VAL_W-1:0] mag64(input logic [VAL_W-1:0] v);
        mag64 = v[VAL_W-1] ? (~v + 64'd1) : v;
    endfunction

endpackage

// ===== hw/rtl/elastic_velocity_moduli_convert_top.sv =====
`timescale 1ns / 1ps
// Top level of the elastic velocity / moduli converter: a chain of bit-step cells.
// Depends on evmc_pkg, evmc_mul_cell, evmc_div_cell and evmc_sqrt_cell.
//
// Usage. Each input transaction on the slave stream carries one model point:
// density (Q.FRAC_BITS unsigned) and two signed 64-bit values. With direction 0
// the block returns shear and bulk modulus; with direction 1 it returns P and S
// speed. Each output transaction on the master stream carries both results and a
// status code (ok, saturated, invalid). The direction register is written through
// i_cfg_we / i_cfg_wdata and takes effect for items accepted afterwards; each
// item carries its own copy of the mode down the chain.
// Throughput is one transaction per cycle while the receiver does not stall. The chain
// holds 96 multiplier cells, three preparation stages, QW divider cells with
// QW = 66 + 2*FRAC_BITS, QW/2 root cells and the output register.
// Reset clears the valid bits of every stage and the direction register; the
// datapath registers are not reset. When the receiver stalls, the whole chain
// holds; it keeps accepting as long as the output register is empty or is
// being taken in the same cycle.
module elastic_velocity_moduli_convert_top #(
    parameter int FRAC_BITS = evmc_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,     // direction
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // density [31:0], first_value [95:32], second_value [159:96]
    input  logic [evmc_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // first_result [63:0], second_result [127:64], status [129:128], zeros above
    output logic [evmc_pkg::OUT_W-1:0] o_m_axis_tdata
);
    localparam int VW   = evmc_pkg::VAL_W;
    localparam int DNW  = evmc_pkg::DENS_W;
    localparam int PW   = evmc_pkg::PROD_W;
    localparam int TW   = evmc_pkg::DIFF_W;
    localparam int MW   = evmc_pkg::MOD_W;
    localparam int DVW  = evmc_pkg::DIV_W;
    localparam int NM   = DNW + VW;          // multiplier cells
    localparam int QW   = MW + 2 * FRAC_BITS; // divider cells and quotient width
    localparam int RW   = QW / 2;            // root cells and root width
    localparam int NTOT = NM + 3 + QW + RW + 1;
    localparam int SH   = 2 * FRAC_BITS;

    // Direction register.
    logic r_dir;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= 1'b0;
        end else if (i_cfg_we) begin
            r_dir <= i_cfg_wdata;
        end
    end

    // Whole chain advances together; it moves whenever the output slot frees up.
    logic            w_en;
    logic [NTOT-1:0] r_vld;

    assign w_en            = ~r_vld[NTOT-1] | i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[NTOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NTOT-2:0], i_s_axis_tvalid};
        end
    end

    evmc_pkg::t_raw w_in_raw;
    assign w_in_raw.dir  = r_dir;
    assign w_in_raw.dens = i_s_axis_tdata[DNW-1:0];
    assign w_in_raw.a    = i_s_axis_tdata[DNW+VW-1:DNW];
    assign w_in_raw.b    = i_s_axis_tdata[DNW+2*VW-1:DNW+VW];

    // ---------------- Multiplier section ----------------
    // First DNW cells multiply |value| by density, the rest multiply that by |value|.
    evmc_pkg::t_raw r_mraw [NM];
    logic [PW-1:0] w_mc_p [NM], w_acc_p [NM], w_mc_s [NM], w_acc_s [NM];
    logic [VW-1:0] w_mp_p [NM], w_mp_s [NM];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mraw[0] <= w_in_raw;
            for (int k = 1; k < NM; k++) begin
                r_mraw[k] <= r_mraw[k-1];
            end
        end
    end

    for (genvar k = 0; k < NM; k++) begin : g_mul
        logic [PW-1:0] w_imc_p, w_iacc_p, w_imc_s, w_iacc_s;
        logic [VW-1:0] w_imp_p, w_imp_s;
        if (k == 0) begin : g_first
            assign w_imc_p  = PW'(evmc_pkg::mag64(w_in_raw.a));
            assign w_imc_s  = PW'(evmc_pkg::mag64(w_in_raw.b));
            assign w_imp_p  = VW'(w_in_raw.dens);
            assign w_imp_s  = VW'(w_in_raw.dens);
            assign w_iacc_p = '0;
            assign w_iacc_s = '0;
        end else if (k == DNW) begin : g_handoff
            assign w_imc_p  = w_acc_p[k-1];
            assign w_imc_s  = w_acc_s[k-1];
            assign w_imp_p  = evmc_pkg::mag64(r_mraw[k-1].a);
            assign w_imp_s  = evmc_pkg::mag64(r_mraw[k-1].b);
            assign w_iacc_p = '0;
            assign w_iacc_s = '0;
        end else begin : g_mid
            assign w_imc_p  = w_mc_p[k-1];
            assign w_imc_s  = w_mc_s[k-1];
            assign w_imp_p  = w_mp_p[k-1];
            assign w_imp_s  = w_mp_s[k-1];
            assign w_iacc_p = w_acc_p[k-1];
            assign w_iacc_s = w_acc_s[k-1];
        end
        evmc_mul_cell #(.AW(PW), .MW(VW)) u_cell_p (
            .i_clk(i_clk), .i_en(w_en), .i_mc(w_imc_p), .i_mp(w_imp_p),
            .i_acc(w_iacc_p), .o_mc(w_mc_p[k]), .o_mp(w_mp_p[k]), .o_acc(w_acc_p[k])
        );
        evmc_mul_cell #(.AW(PW), .MW(VW)) u_cell_s (
            .i_clk(i_clk), .i_en(w_en), .i_mc(w_imc_s), .i_mp(w_imp_s),
            .i_acc(w_iacc_s), .o_mc(w_mc_s[k]), .o_mp(w_mp_s[k]), .o_acc(w_acc_s[k])
        );
    end

    // ---------------- Preparation stages ----------------
    // Stage one: scale products, form 3*Y and 4*X; reverse mode forms 3|bulk|, 4*shear.
    logic [PW-1:0] w_x, w_y;
    logic [VW-1:0] w_bmag;
    evmc_pkg::t_raw w_praw;

    assign w_praw = r_mraw[NM-1];
    assign w_x    = w_acc_s[NM-1] >> SH;
    assign w_y    = w_acc_p[NM-1] >> SH;
    assign w_bmag = evmc_pkg::mag64(w_praw.b);

    logic            r_p1_dir, r_p1_satx, r_p1_bad, r_p1_bneg;
    logic [62:0]     r_p1_xlo, r_p1_apos;
    logic [TW-1:0]   r_p1_t3, r_p1_t4;
    logic [MW-1:0]   r_p1_t3r, r_p1_t4r;
    logic [DVW-1:0]  r_p1_div3;
    logic [DNW-1:0]  r_p1_dens;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_dir  <= w_praw.dir;
            r_p1_satx <= |w_x[PW-1:63];
            r_p1_xlo  <= w_x[62:0];
            r_p1_t3   <= TW'(w_y) + (TW'(w_y) << 1);
            r_p1_t4   <= TW'(w_x) << 2;
            r_p1_bad  <= (w_praw.dens == '0) | w_praw.a[VW-1];
            r_p1_bneg <= w_praw.b[VW-1];
            r_p1_t3r  <= MW'(w_bmag) + (MW'(w_bmag) << 1);
            r_p1_t4r  <= MW'(w_praw.a[62:0]) << 2;
            r_p1_div3 <= DVW'(w_praw.dens) + (DVW'(w_praw.dens) << 1);
            r_p1_dens <= w_praw.dens;
            r_p1_apos <= w_praw.a[62:0];
        end
    end

    // Stage two: signed difference as sign and magnitude; reverse sum or difference.
    logic [TW:0]   w_dp;
    logic [TW-1:0] w_dn;
    logic [MW-1:0] w_msum;
    logic [MW:0]   w_mdif;

    assign w_dp   = {1'b0, r_p1_t3} - {1'b0, r_p1_t4};
    assign w_dn   = r_p1_t4 - r_p1_t3;
    assign w_msum = r_p1_t4r + r_p1_t3r;
    assign w_mdif = {1'b0, r_p1_t4r} - {1'b0, r_p1_t3r};

    logic            r_p2_dir, r_p2_satx, r_p2_neg, r_p2_bad;
    logic [62:0]     r_p2_xlo, r_p2_apos;
    logic [TW-1:0]   r_p2_t;
    logic [MW-1:0]   r_p2_m3;
    logic [DVW-1:0]  r_p2_div3;
    logic [DNW-1:0]  r_p2_dens;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_dir  <= r_p1_dir;
            r_p2_satx <= r_p1_satx;
            r_p2_xlo  <= r_p1_xlo;
            r_p2_neg  <= w_dp[TW];
            r_p2_t    <= w_dp[TW] ? w_dn : w_dp[TW-1:0];
            r_p2_m3   <= r_p1_bneg ? w_mdif[MW-1:0] : w_msum;
            r_p2_bad  <= r_p1_bad | (r_p1_bneg & w_mdif[MW]);
            r_p2_div3 <= r_p1_div3;
            r_p2_dens <= r_p1_dens;
            r_p2_apos <= r_p1_apos;
        end
    end

    // Stage three: bulk saturation test and divider operands.
    logic w_t_high, w_satb;
    assign w_t_high = |r_p2_t[TW-1:MW];
    assign w_satb   = w_t_high | (r_p2_neg ? (r_p2_t[MW-1:0] >= evmc_pkg::LIM_NEG)
                                           : (r_p2_t[MW-1:0] >= evmc_pkg::LIM_POS));

    evmc_pkg::t_tag r_d0_tag;
    logic [QW-1:0]  r_d0_nq1, r_d0_nq2;
    logic [DVW-1:0] r_d0_div1, r_d0_div2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d0_tag.dir   <= r_p2_dir;
            r_d0_tag.sat_x <= r_p2_satx;
            r_d0_tag.x_lo  <= r_p2_xlo;
            r_d0_tag.neg   <= r_p2_neg;
            r_d0_tag.sat_b <= w_satb;
            r_d0_tag.bad   <= r_p2_bad;
            r_d0_nq1       <= r_p2_dir ? (QW'(r_p2_m3) << SH) : QW'(r_p2_t[MW-1:0]);
            r_d0_div1      <= r_p2_dir ? r_p2_div3 : evmc_pkg::DIV_THREE;
            r_d0_nq2       <= QW'(r_p2_apos) << SH;
            r_d0_div2      <= DVW'(r_p2_dens);
        end
    end

    // ---------------- Divider section ----------------
    evmc_pkg::t_tag r_dtag [QW];
    logic [DVW-1:0] w_rem1 [QW], w_rem2 [QW], w_div1 [QW], w_div2 [QW];
    logic [QW-1:0]  w_nq1 [QW], w_nq2 [QW];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dtag[0] <= r_d0_tag;
            for (int j = 1; j < QW; j++) begin
                r_dtag[j] <= r_dtag[j-1];
            end
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [DVW-1:0] w_irem1, w_irem2, w_idiv1, w_idiv2;
        logic [QW-1:0]  w_inq1, w_inq2;
        if (j == 0) begin : g_first
            assign w_irem1 = '0;
            assign w_irem2 = '0;
            assign w_inq1  = r_d0_nq1;
            assign w_inq2  = r_d0_nq2;
            assign w_idiv1 = r_d0_div1;
            assign w_idiv2 = r_d0_div2;
        end else begin : g_mid
            assign w_irem1 = w_rem1[j-1];
            assign w_irem2 = w_rem2[j-1];
            assign w_inq1  = w_nq1[j-1];
            assign w_inq2  = w_nq2[j-1];
            assign w_idiv1 = w_div1[j-1];
            assign w_idiv2 = w_div2[j-1];
        end
        evmc_div_cell #(.NW(QW), .DW(DVW)) u_cell_1 (
            .i_clk(i_clk), .i_en(w_en), .i_rem(w_irem1), .i_nq(w_inq1), .i_div(w_idiv1),
            .o_rem(w_rem1[j]), .o_nq(w_nq1[j]), .o_div(w_div1[j])
        );
        evmc_div_cell #(.NW(QW), .DW(DVW)) u_cell_2 (
            .i_clk(i_clk), .i_en(w_en), .i_rem(w_irem2), .i_nq(w_inq2), .i_div(w_idiv2),
            .o_rem(w_rem2[j]), .o_nq(w_nq2[j]), .o_div(w_div2[j])
        );
    end

    // ---------------- Root section ----------------
    // Forward items keep their bulk quotient beside the root cells.
    evmc_pkg::t_tag r_stag [RW];
    logic [VW-1:0]  r_sfq  [RW];
    logic [RW+1:0]  w_srem1 [RW], w_srem2 [RW];
    logic [RW-1:0]  w_root1 [RW], w_root2 [RW];
    logic [QW-1:0]  w_rad1 [RW], w_rad2 [RW];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stag[0] <= r_dtag[QW-1];
            r_sfq[0]  <= w_nq1[QW-1][VW-1:0];
            for (int j = 1; j < RW; j++) begin
                r_stag[j] <= r_stag[j-1];
                r_sfq[j]  <= r_sfq[j-1];
            end
        end
    end

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        logic [RW+1:0] w_irem1, w_irem2;
        logic [RW-1:0] w_iroot1, w_iroot2;
        logic [QW-1:0] w_irad1, w_irad2;
        if (j == 0) begin : g_first
            assign w_irem1  = '0;
            assign w_irem2  = '0;
            assign w_iroot1 = '0;
            assign w_iroot2 = '0;
            assign w_irad1  = w_nq1[QW-1];
            assign w_irad2  = w_nq2[QW-1];
        end else begin : g_mid
            assign w_irem1  = w_srem1[j-1];
            assign w_irem2  = w_srem2[j-1];
            assign w_iroot1 = w_root1[j-1];
            assign w_iroot2 = w_root2[j-1];
            assign w_irad1  = w_rad1[j-1];
            assign w_irad2  = w_rad2[j-1];
        end
        evmc_sqrt_cell #(.NW(QW), .RW(RW)) u_cell_1 (
            .i_clk(i_clk), .i_en(w_en), .i_rem(w_irem1), .i_root(w_iroot1), .i_rad(w_irad1),
            .o_rem(w_srem1[j]), .o_root(w_root1[j]), .o_rad(w_rad1[j])
        );
        evmc_sqrt_cell #(.NW(QW), .RW(RW)) u_cell_2 (
            .i_clk(i_clk), .i_en(w_en), .i_rem(w_irem2), .i_root(w_iroot2), .i_rad(w_irad2),
            .o_rem(w_srem2[j]), .o_root(w_root2[j]), .o_rad(w_rad2[j])
        );
    end

    // ---------------- Output register ----------------
    evmc_pkg::t_tag   w_ot;
    logic [VW-1:0]    w_fq, n_first, n_second;
    evmc_pkg::t_status n_status;

    assign w_ot = r_stag[RW-1];
    assign w_fq = r_sfq[RW-1];

    always_comb begin
        if (w_ot.dir) begin
            if (w_ot.bad) begin
                n_first  = '0;
                n_second = '0;
                n_status = evmc_pkg::ST_INVALID;
            end else begin
                n_first  = VW'(w_root1[RW-1]);
                n_second = VW'(w_root2[RW-1]);
                n_status = evmc_pkg::ST_OK;
            end
        end else begin
            n_first = w_ot.sat_x ? evmc_pkg::S64_MAX : {1'b0, w_ot.x_lo};
            if (w_ot.sat_b) begin
                n_second = w_ot.neg ? evmc_pkg::S64_MIN : evmc_pkg::S64_MAX;
            end else begin
                n_second = w_ot.neg ? (~w_fq + 64'd1) : w_fq;
            end
            n_status = (w_ot.sat_x | w_ot.sat_b) ? evmc_pkg::ST_SAT : evmc_pkg::ST_OK;
        end
    end

    logic [VW-1:0]     r_out_first, r_out_second;
    evmc_pkg::t_status r_out_status;
    logic              r_out_dir;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_first  <= n_first;
            r_out_second <= n_second;
            r_out_status <= n_status;
            r_out_dir    <= w_ot.dir;
        end
    end

    assign o_m_axis_tdata = {6'b000000, r_out_status, r_out_second, r_out_first};

    // ---------------- Assertions ----------------
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("stage valids moved during a stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted transaction did not enter the chain");

    a_rev_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out_dir) |-> (r_out_status != evmc_pkg::ST_SAT))
        else $error("reverse mode reported saturation");

    a_fwd_no_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !r_out_dir) |-> (r_out_status != evmc_pkg::ST_INVALID))
        else $error("forward mode reported an invalid point");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out_status == evmc_pkg::ST_INVALID)
            |-> (r_out_first == '0 && r_out_second == '0))
        else $error("invalid point carried nonzero results");

endmodule

// ===== hw/rtl/evmc_mul_cell.sv =====
`timescale 1ns / 1ps
// One shift-and-add step of a multiplier chain: consumes one multiplier bit.
// Depends on nothing but its parameters.
module evmc_mul_cell #(
    parameter int AW = 160,
    parameter int MW = 64
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_mc,
    input  logic [MW-1:0] i_mp,
    input  logic [AW-1:0] i_acc,
    output logic [AW-1:0] o_mc,
    output logic [MW-1:0] o_mp,
    output logic [AW-1:0] o_acc
);
    logic [AW-1:0] r_mc, r_acc, n_acc;
    logic [MW-1:0] r_mp;

    assign n_acc = i_acc + (i_mp[0] ? i_mc : '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mc  <= i_mc << 1;
            r_mp  <= i_mp >> 1;
            r_acc <= n_acc;
        end
    end

    assign o_mc  = r_mc;
    assign o_mp  = r_mp;
    assign o_acc = r_acc;
endmodule

// ===== hw/rtl/evmc_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring division step: takes the next dividend bit, yields one quotient bit.
// Dividend and quotient share one shift register. No package dependency.
module evmc_div_cell #(
    parameter int NW = 82,
    parameter int DW = 34
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [NW-1:0] i_nq,
    input  logic [DW-1:0] i_div,
    output logic [DW-1:0] o_rem,
    output logic [NW-1:0] o_nq,
    output logic [DW-1:0] o_div
);
    logic [DW:0]   n_trial;
    logic [DW+1:0] n_diff;
    logic          n_ge;
    logic [DW-1:0] r_rem, r_div;
    logic [NW-1:0] r_nq;

    assign n_trial = {i_rem, i_nq[NW-1]};
    assign n_diff  = {1'b0, n_trial} - {2'b00, i_div};
    assign n_ge    = ~n_diff[DW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
            r_nq  <= {i_nq[NW-2:0], n_ge};
            r_div <= i_div;
        end
    end

    assign o_rem = r_rem;
    assign o_nq  = r_nq;
    assign o_div = r_div;
endmodule

// ===== hw/rtl/evmc_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One restoring square root step: brings in two radicand bits, yields one root bit.
// No package dependency.
module evmc_sqrt_cell #(
    parameter int NW = 82,
    parameter int RW = 41
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW+1:0] i_rem,
    input  logic [RW-1:0] i_root,
    input  logic [NW-1:0] i_rad,
    output logic [RW+1:0] o_rem,
    output logic [RW-1:0] o_root,
    output logic [NW-1:0] o_rad
);
    logic [RW+3:0] n_cur, n_trial;
    logic [RW+4:0] n_diff;
    logic          n_ge;
    logic [RW+1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [NW-1:0] r_rad;

    assign n_cur   = {i_rem, i_rad[NW-1:NW-2]};
    assign n_trial = (RW+4)'({i_root, 2'b01});
    assign n_diff  = {1'b0, n_cur} - {1'b0, n_trial};
    assign n_ge    = ~n_diff[RW+4];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_ge ? n_diff[RW+1:0] : n_cur[RW+1:0];
            r_root <= {i_root[RW-2:0], n_ge};
            r_rad  <= {i_rad[NW-3:0], 2'b00};
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
endmodule

// ===== tb/sv/tb_elastic_velocity_moduli_convert_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for elastic_velocity_moduli_convert_top: streams model points in both
// directions under several handshake pressure phases and checks every result.
// Depends on evmc_pkg and the top level of the converter.
module tb_elastic_velocity_moduli_convert_top;

    localparam int FRAC = 8;
    localparam int LATENCY = 96 + 3 + (66 + 2 * FRAC) + (66 + 2 * FRAC) / 2 + 1;
    localparam int STALL_LIMIT = 20000;

    localparam logic DIR_FORWARD = 1'b0;
    localparam logic DIR_REVERSE = 1'b1;

    typedef struct packed {
        logic [63:0] first;
        logic [63:0] second;
        logic [1:0]  status;
    } t_point_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    logic i_s_axis_tvalid;
    logic o_s_axis_tready;
    logic [evmc_pkg::IN_W-1:0] i_s_axis_tdata;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready;
    logic [evmc_pkg::OUT_W-1:0] o_m_axis_tdata;

    elastic_velocity_moduli_convert_top #(.FRAC_BITS(FRAC)) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)
    );

    // Local copy of the direction register and the queue of predicted results.
    logic          mode_dir;
    t_point_result moduli_expected[$];
    int            error_count;
    int            idle_cycles;
    int            sender_idle_pct;
    int            receiver_stall_pct;
    int            hold_off_cycles;   // receiver forced low while this is nonzero

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Integer square root of a wide unsigned value, bit by bit from the top.
    function automatic logic [63:0] isqrt_wide(input logic [191:0] arg);
        logic [63:0]  root;
        logic [63:0]  trial;
        logic [191:0] sq;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            sq = 192'(trial) * 192'(trial);
            if (sq <= arg) root = trial;
        end
        return root;
    endfunction

    // Predicts one conversion from the mode held at acceptance time.
    function automatic t_point_result convert_point(input logic dir, input logic [31:0] dens,
                                                    input logic [63:0] a, input logic [63:0] b);
        t_point_result res;
        logic [191:0] pa, sa, shear, pm, t3, t4, diff, m3, q;
        logic         sat, neg, bad;
        res = '0;
        if (dir == DIR_FORWARD) begin
            sat = 1'b0;
            pa = 192'(evmc_pkg::mag64(a));
            sa = 192'(evmc_pkg::mag64(b));
            shear = (sa * sa * 192'(dens)) >> (2 * FRAC);
            pm = (pa * pa * 192'(dens)) >> (2 * FRAC);
            if (shear > 192'(evmc_pkg::S64_MAX)) begin
                res.first = evmc_pkg::S64_MAX;
                sat = 1'b1;
            end else begin
                res.first = shear[63:0];
            end
            t3 = pm * 3;
            t4 = shear * 4;
            neg = t3 < t4;
            diff = (neg ? t4 - t3 : t3 - t4) / 3;
            if (neg) begin
                if (diff > 192'(evmc_pkg::S64_MIN)) begin
                    res.second = evmc_pkg::S64_MIN;
                    sat = 1'b1;
                end else begin
                    res.second = -diff[63:0];
                end
            end else if (diff > 192'(evmc_pkg::S64_MAX)) begin
                res.second = evmc_pkg::S64_MAX;
                sat = 1'b1;
            end else begin
                res.second = diff[63:0];
            end
            res.status = sat ? evmc_pkg::ST_SAT : evmc_pkg::ST_OK;
        end else begin
            bad = (dens == 0) || a[63];
            m3 = '0;
            if (!bad) begin
                t3 = 192'(evmc_pkg::mag64(b)) * 3;
                t4 = 192'(a) * 4;
                if (!b[63]) m3 = t4 + t3;
                else if (t4 >= t3) m3 = t4 - t3;
                else bad = 1'b1;
            end
            if (bad) begin
                res.status = evmc_pkg::ST_INVALID;
            end else begin
                q = (m3 << (2 * FRAC)) / (192'(dens) * 3);
                res.first = isqrt_wide(q);
                q = (192'(a) << (2 * FRAC)) / 192'(dens);
                res.second = isqrt_wide(q);
                res.status = evmc_pkg::ST_OK;
            end
        end
        return res;
    endfunction

    // Sends one point; the prediction is queued when the transaction is accepted.
    // The valid stays high on return so that the next point can follow directly.
    task automatic send_point(input logic [31:0] dens, input logic [63:0] a,
                              input logic [63:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {b, a, dens};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        moduli_expected.push_back(convert_point(mode_dir, dens, a, b));
        @(negedge i_clk);
    endtask

    // Waits for every result, lets the chain drain, then writes the direction.
    task automatic set_direction(input logic dir);
        i_s_axis_tvalid <= 1'b0;
        while (moduli_expected.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= dir;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mode_dir = dir;
    endtask

    // Random 64-bit value, biased toward small magnitudes that keep results in range.
    function automatic logic [63:0] rand_value(input bit small_only);
        logic [63:0] v;
        int          bits;
        v = {$urandom, $urandom};
        bits = small_only ? $urandom_range(40, 4) : $urandom_range(64, 1);
        if (bits < 64) v = v & ((64'd1 << bits) - 1);
        if ($urandom_range(3) == 0) v = -v;
        return v;
    endfunction

    function automatic logic [31:0] rand_density();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'd1;
            default: return $urandom_range(32'h0010_0000, 32'd1);
        endcase
    endfunction

    task automatic test_forward_corners();
        send_point(32'd256, 64'd512, 64'd256);
        send_point(32'd0, 64'd1000, 64'd999);
        send_point(32'hFFFF_FFFF, evmc_pkg::S64_MAX, evmc_pkg::S64_MAX);
        send_point(32'hFFFF_FFFF, evmc_pkg::S64_MIN, 64'd0);
        send_point(32'hFFFF_FFFF, 64'd0, evmc_pkg::S64_MIN);
        send_point(32'd256, 64'd0, 64'd256);
        send_point(32'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF);
        send_point(32'h8000_0000, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
        send_point(32'd256, -64'sd768, -64'sd512);
    endtask

    task automatic test_reverse_corners();
        send_point(32'd256, 64'd256, 64'd256);
        send_point(32'd0, 64'd256, 64'd256);
        send_point(32'd256, evmc_pkg::S64_MIN, 64'd0);
        send_point(32'd256, 64'd3, -64'sd5);
        send_point(32'd256, 64'd3, -64'sd4);
        send_point(32'd1, evmc_pkg::S64_MAX, evmc_pkg::S64_MAX);
        send_point(32'hFFFF_FFFF, 64'd0, 64'd0);
        send_point(32'd1, evmc_pkg::S64_MAX, evmc_pkg::S64_MIN);
        send_point(32'hFFFF_FFFF, 64'd1, evmc_pkg::S64_MAX);
    endtask

    task automatic test_random_points(input int count);
        for (int n = 0; n < count; n++) begin
            send_point(rand_density(), rand_value($urandom_range(3) != 0),
                       rand_value($urandom_range(3) != 0));
        end
    endtask

    // Receiver holds off long enough for the whole chain to fill while points keep coming.
    task automatic test_backpressure_fill();
        hold_off_cycles = LATENCY + 150;
        test_random_points(LATENCY + 60);
    endtask

    task automatic run_phases(input int per_phase);
        sender_idle_pct = 0;  receiver_stall_pct = 0;  test_random_points(per_phase);
        sender_idle_pct = 61; receiver_stall_pct = 0;  test_random_points(per_phase);
        sender_idle_pct = 0;  receiver_stall_pct = 61; test_random_points(per_phase);
        sender_idle_pct = 26; receiver_stall_pct = 26; test_random_points(per_phase);
        sender_idle_pct = 0;  receiver_stall_pct = 0;
    endtask

    // Receiver: random stalls, a counted hold-off window, and the result check.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_point_result want;
        t_point_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{o_m_axis_tdata[63:0], o_m_axis_tdata[127:64], o_m_axis_tdata[129:128]};
            if (moduli_expected.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = moduli_expected.pop_front();
                if (got.first !== want.first || got.second !== want.second ||
                    got.status !== want.status ||
                    o_m_axis_tdata[evmc_pkg::OUT_W-1:130] !== '0) begin
                    $display("%0t: expected %h %h %0d, actual %h %h %0d", $time,
                             want.first, want.second, want.status,
                             got.first, got.second, got.status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles without any transaction on either side.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("elastic_velocity_moduli_convert_top: mismatch");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_cycles = 0;
        mode_dir = DIR_FORWARD;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Forward mode straight out of reset, then explicit writes of both values.
        test_forward_corners();
        set_direction(DIR_REVERSE);
        test_reverse_corners();
        run_phases(100);
        test_backpressure_fill();
        set_direction(DIR_FORWARD);
        run_phases(100);
        set_direction(DIR_REVERSE);
        test_random_points(60);
        set_direction(DIR_FORWARD);
        test_random_points(60);

        i_s_axis_tvalid <= 1'b0;
        while (moduli_expected.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        if (error_count == 0) begin
            $display("elastic_velocity_moduli_convert_top: match");
        end else begin
            $display("elastic_velocity_moduli_convert_top: mismatch");
        end
        $finish;
    end
endmodule
